// File: rtl/mlbf_pkg.sv
// shared types and constants for the multi-led blink and flash controller
package mlbf_pkg;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned STEP_W    = 9;
    localparam int unsigned ADDR_LEDS = 4;
    localparam int unsigned S_DATA_W  = 32;
    localparam int unsigned M_DATA_W  = 8;

    localparam logic [STEP_W-1:0] RESET_PERIOD = 9'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK        = 2'd0,
        CMD_SET_CONST   = 2'd1,
        CMD_SET_BLINK   = 2'd2,
        CMD_START_FLASH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_CONST = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_FLASH = 2'd2
    } mode_t;

    // request payload, led_index in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] flash_count;
        logic [COUNT_W-1:0] off_ticks;
        logic [COUNT_W-1:0] on_ticks;
        logic               level;
        logic [IDX_W-1:0]   led_index;
    } req_t;

    localparam int unsigned REQ_W = $bits(req_t);

    // per-led update strobes and operands
    typedef struct packed {
        logic               tick;
        logic               set_const;
        logic               set_blink;
        logic               start_flash;
        logic               level;
        logic [COUNT_W-1:0] on_ticks;
        logic [COUNT_W-1:0] off_ticks;
        logic [COUNT_W-1:0] flash_count;
    } led_ctl_t;

endpackage

// File: rtl/mlbf_led.sv
// state and update logic of one led channel
module mlbf_led (
    input  logic                aclk,
    input  logic                aresetn,
    input  mlbf_pkg::led_ctl_t  ctl,
    output logic                level_o,
    output logic                active_o
);

    mlbf_pkg::mode_t                       mode_reg, mode_next;
    logic [mlbf_pkg::COUNT_W-1:0]          on_count_reg, on_count_next;
    logic [mlbf_pkg::STEP_W-1:0]           period_reg, period_next;
    logic [mlbf_pkg::STEP_W-1:0]           step_reg, step_next;
    logic                                  level_reg, level_next;

    logic [mlbf_pkg::STEP_W-1:0]           step_inc;
    logic [mlbf_pkg::COUNT_W-1:0]          count_dec;
    logic [mlbf_pkg::STEP_W-1:0]           blink_period;
    logic                                  blink_changed;

    assign step_inc     = step_reg + 1'b1;
    assign count_dec    = on_count_reg - 1'b1;
    // sum kept at full 9 bits
    assign blink_period = {1'b0, ctl.on_ticks} + {1'b0, ctl.off_ticks};
    assign blink_changed = (mode_reg != mlbf_pkg::MODE_BLINK)
                        || (on_count_reg != ctl.on_ticks)
                        || (period_reg != blink_period);

    always_comb begin
        mode_next     = mode_reg;
        on_count_next = on_count_reg;
        period_next   = period_reg;
        step_next     = step_reg;
        level_next    = level_reg;
        if (ctl.tick) begin
            unique case (mode_reg)
                mlbf_pkg::MODE_BLINK: begin
                    step_next = step_inc;
                    if (step_inc == {1'b0, on_count_reg}) begin
                        level_next = 1'b0;
                    end else if (step_inc >= period_reg) begin
                        step_next = '0;
                        if (on_count_reg != '0) begin
                            level_next = 1'b1;
                        end
                    end
                end
                mlbf_pkg::MODE_FLASH: begin
                    step_next = step_inc;
                    if (step_inc[0]) begin
                        level_next = 1'b1;
                    end else begin
                        level_next    = 1'b0;
                        on_count_next = count_dec;
                        if (count_dec == '0) begin
                            mode_next = mlbf_pkg::MODE_CONST;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (ctl.set_const) begin
            mode_next  = mlbf_pkg::MODE_CONST;
            level_next = ctl.level;
        end else if (ctl.set_blink) begin
            priority if (ctl.on_ticks == '0) begin
                mode_next  = mlbf_pkg::MODE_CONST;
                level_next = 1'b0;
            end else if (ctl.off_ticks == '0) begin
                mode_next  = mlbf_pkg::MODE_CONST;
                level_next = 1'b1;
            end else begin
                mode_next     = mlbf_pkg::MODE_BLINK;
                on_count_next = ctl.on_ticks;
                period_next   = blink_period;
                // an unchanged setting leaves the running cycle alone
                if (blink_changed) begin
                    step_next  = '0;
                    level_next = 1'b1;
                end
            end
        end else if (ctl.start_flash) begin
            if (ctl.flash_count == '0) begin
                mode_next  = mlbf_pkg::MODE_CONST;
                level_next = 1'b0;
            end else begin
                mode_next     = mlbf_pkg::MODE_FLASH;
                on_count_next = ctl.flash_count;
                step_next     = '0;
                level_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= mlbf_pkg::MODE_CONST;
            on_count_reg <= '0;
            period_reg   <= mlbf_pkg::RESET_PERIOD;
            step_reg     <= '0;
            level_reg    <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            on_count_reg <= on_count_next;
            period_reg   <= period_next;
            step_reg     <= step_next;
            level_reg    <= level_next;
        end
    end

    // level and mode as they stand once this cycle's request has acted
    assign level_o  = level_next;
    assign active_o = (mode_next != mlbf_pkg::MODE_CONST);

endmodule

// File: rtl/multi_led_blink_flash_controller_unit.sv
// top level: input register, led channels and result register
// a request reaches m_tdata via the input register and then the result register
// throughput: one request per cycle unless stalled; all led channels update in parallel
// a stalled result holds in the output register; the input register takes one more request
// reset (aresetn low, synchronous): both stages empty, every led constant off, period ten
module multi_led_blink_flash_controller_unit #(
    parameter int unsigned NUM_LEDS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // led_index[1:0], level[2], on_ticks[10:3], off_ticks[18:11], flash_count[26:19]
    input  logic [mlbf_pkg::S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [mlbf_pkg::CMD_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // led_levels[3:0], active_mask[7:4]
    output logic [mlbf_pkg::M_DATA_W-1:0] m_tdata
);

    logic                 in_valid_reg;
    mlbf_pkg::req_t       in_req_reg;
    mlbf_pkg::cmd_t       in_cmd_reg;
    logic                 out_valid_reg;
    logic [mlbf_pkg::ADDR_LEDS-1:0] levels_reg, active_reg;
    logic [mlbf_pkg::ADDR_LEDS-1:0] levels_next, active_next;

    logic                 out_free;
    logic                 fire;
    logic [NUM_LEDS-1:0]  led_level;
    logic [NUM_LEDS-1:0]  led_active;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_cmd_reg <= mlbf_pkg::CMD_TICK;
        end else if (s_tvalid && s_tready) begin
            in_req_reg <= mlbf_pkg::req_t'(s_tdata[mlbf_pkg::REQ_W-1:0]);
            in_cmd_reg <= mlbf_pkg::cmd_t'(s_tuser);
        end
    end

    genvar i;
    generate
        for (i = 0; i < NUM_LEDS; i++) begin : g_led
            // only the first four leds can be addressed
            localparam bit ADDRESSABLE = (i < mlbf_pkg::ADDR_LEDS);
            localparam logic [mlbf_pkg::IDX_W-1:0] LED_IDX = mlbf_pkg::IDX_W'(i);

            mlbf_pkg::led_ctl_t ctl;
            logic               sel;

            assign sel = fire && ADDRESSABLE && (in_req_reg.led_index == LED_IDX);

            always_comb begin
                ctl             = '0;
                ctl.level       = in_req_reg.level;
                ctl.on_ticks    = in_req_reg.on_ticks;
                ctl.off_ticks   = in_req_reg.off_ticks;
                ctl.flash_count = in_req_reg.flash_count;
                unique case (in_cmd_reg)
                    mlbf_pkg::CMD_TICK:        ctl.tick        = fire;
                    mlbf_pkg::CMD_SET_CONST:   ctl.set_const   = sel;
                    mlbf_pkg::CMD_SET_BLINK:   ctl.set_blink   = sel;
                    mlbf_pkg::CMD_START_FLASH: ctl.start_flash = sel;
                endcase
            end

            mlbf_led u_led (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .level_o  (led_level[i]),
                .active_o (led_active[i])
            );
        end
    endgenerate

    // result shows the state after the request has acted
    genvar j;
    generate
        for (j = 0; j < mlbf_pkg::ADDR_LEDS; j++) begin : g_report
            if (j < NUM_LEDS) begin : g_on
                assign levels_next[j] = led_level[j];
                assign active_next[j] = led_active[j];
            end else begin : g_off
                assign levels_next[j] = 1'b0;
                assign active_next[j] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            levels_reg <= levels_next;
            active_reg <= active_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {active_reg, levels_reg};

endmodule

// File: rtl/mlbf_checker.sv
// port-level checks for the controller, bound to the top level
module mlbf_checker #(
    parameter int unsigned NUM_LEDS = 4
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mlbf_pkg::M_DATA_W-1:0] m_tdata
);

    localparam logic [mlbf_pkg::ADDR_LEDS-1:0] LED_MASK =
        (NUM_LEDS >= mlbf_pkg::ADDR_LEDS) ? '1
                                          : mlbf_pkg::ADDR_LEDS'((1 << NUM_LEDS) - 1);
    localparam logic [mlbf_pkg::M_DATA_W-1:0] USED_MASK = {LED_MASK, LED_MASK};

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_absent_leds_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata & ~USED_MASK) == '0)
        else $error("absent led reported as on or active");

endmodule

bind multi_led_blink_flash_controller_unit mlbf_checker #(
    .NUM_LEDS (NUM_LEDS)
) u_mlbf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/tb_multi_led_blink_flash_controller_unit.sv
// testbench for the multi-led blink and flash controller: stream driver, predictor, checker
`timescale 1ns / 1ps

module tb_multi_led_blink_flash_controller_unit;

    localparam int unsigned NLEDS       = 4;
    localparam int unsigned N_RANDOM    = 1100;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned TAIL_CYCLES = 8;

    typedef struct {
        mlbf_pkg::cmd_t cmd;
        mlbf_pkg::req_t req;
    } led_req_t;

    // packed so that levels sit in the low nibble, as on m_tdata
    typedef struct packed {
        logic [3:0] active;
        logic [3:0] levels;
    } lamp_res_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mlbf_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [mlbf_pkg::CMD_W-1:0]    s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mlbf_pkg::M_DATA_W-1:0] m_tdata;

    multi_led_blink_flash_controller_unit #(
        .NUM_LEDS(NLEDS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // predicted led state
    mlbf_pkg::mode_t              led_mode_m [NLEDS];
    logic [mlbf_pkg::COUNT_W-1:0] led_on_cnt [NLEDS];
    logic [mlbf_pkg::STEP_W-1:0]  led_period [NLEDS];
    logic [mlbf_pkg::STEP_W-1:0]  led_step   [NLEDS];
    logic                         led_lit    [NLEDS];

    led_req_t    pending_reqs[$];
    lamp_res_t   lamp_exp_q[$];
    led_req_t    on_bus;
    int unsigned n_total    = 0;
    int unsigned n_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned tx_gap     = 0;
    int unsigned tx_calm    = 0;
    int unsigned rx_gap     = 0;
    int unsigned rx_calm    = 0;
    bit          draining   = 1'b0;

    // last blink times handed to each led, to repeat a set-blink unchanged
    logic [mlbf_pkg::COUNT_W-1:0] last_on  [NLEDS];
    logic [mlbf_pkg::COUNT_W-1:0] last_off [NLEDS];

    function automatic void clear_led_model();
        for (int i = 0; i < NLEDS; i++) begin
            led_mode_m[i] = mlbf_pkg::MODE_CONST;
            led_on_cnt[i] = '0;
            led_period[i] = mlbf_pkg::RESET_PERIOD;
            led_step[i]   = '0;
            led_lit[i]    = 1'b0;
        end
    endfunction

    function automatic void go_constant(int i, logic lvl);
        led_mode_m[i] = mlbf_pkg::MODE_CONST;
        led_lit[i]    = lvl;
    endfunction

    function automatic lamp_res_t apply_led_request(led_req_t r);
        lamp_res_t                   res;
        int                          idx;
        logic [mlbf_pkg::STEP_W-1:0] per;
        bit                          changed;
        res     = '0;
        idx     = int'(r.req.led_index);
        changed = 1'b0;
        if (r.cmd == mlbf_pkg::CMD_TICK) begin
            for (int i = 0; i < NLEDS; i++) begin
                if (led_mode_m[i] == mlbf_pkg::MODE_BLINK) begin
                    led_step[i] = led_step[i] + 1'b1;
                    if (led_step[i] == {1'b0, led_on_cnt[i]}) begin
                        led_lit[i] = 1'b0;
                    end else if (led_step[i] >= led_period[i]) begin
                        led_step[i] = '0;
                        if (led_on_cnt[i] != 0) led_lit[i] = 1'b1;
                    end
                end else if (led_mode_m[i] == mlbf_pkg::MODE_FLASH) begin
                    led_step[i] = led_step[i] + 1'b1;
                    if (led_step[i][0]) begin
                        led_lit[i] = 1'b1;
                    end else begin
                        led_lit[i]    = 1'b0;
                        led_on_cnt[i] = led_on_cnt[i] - 1'b1;
                        if (led_on_cnt[i] == 0) led_mode_m[i] = mlbf_pkg::MODE_CONST;
                    end
                end
            end
        end else if (idx < NLEDS) begin
            case (r.cmd)
                mlbf_pkg::CMD_SET_CONST: begin
                    go_constant(idx, r.req.level);
                end
                mlbf_pkg::CMD_SET_BLINK: begin
                    if (r.req.on_ticks == 0) begin
                        go_constant(idx, 1'b0);
                    end else if (r.req.off_ticks == 0) begin
                        go_constant(idx, 1'b1);
                    end else begin
                        // period kept at nine bits, no truncation of the sum
                        per = {1'b0, r.req.on_ticks} + {1'b0, r.req.off_ticks};
                        if (led_mode_m[idx] != mlbf_pkg::MODE_BLINK) begin
                            changed         = 1'b1;
                            led_mode_m[idx] = mlbf_pkg::MODE_BLINK;
                        end
                        if (led_on_cnt[idx] != r.req.on_ticks) begin
                            changed         = 1'b1;
                            led_on_cnt[idx] = r.req.on_ticks;
                        end
                        if (led_period[idx] != per) begin
                            changed         = 1'b1;
                            led_period[idx] = per;
                        end
                        if (changed) begin
                            led_step[idx] = '0;
                            led_lit[idx]  = (led_on_cnt[idx] != 0);
                        end
                    end
                end
                default: begin
                    if (r.req.flash_count == 0) begin
                        go_constant(idx, 1'b0);
                    end else begin
                        led_mode_m[idx] = mlbf_pkg::MODE_FLASH;
                        led_on_cnt[idx] = r.req.flash_count;
                        led_step[idx]   = '0;
                        led_lit[idx]    = 1'b0;
                    end
                end
            endcase
        end
        for (int i = 0; i < NLEDS && i < 4; i++) begin
            res.levels[i] = led_lit[i];
            res.active[i] = (led_mode_m[i] != mlbf_pkg::MODE_CONST);
        end
        return res;
    endfunction

    function automatic void queue_req(mlbf_pkg::cmd_t cmd, int idx, logic lvl,
                                      logic [7:0] on_t, logic [7:0] off_t, logic [7:0] n);
        led_req_t r;
        r.cmd               = cmd;
        r.req.led_index     = mlbf_pkg::IDX_W'(idx);
        r.req.level         = lvl;
        r.req.on_ticks      = on_t;
        r.req.off_ticks     = off_t;
        r.req.flash_count   = n;
        pending_reqs.push_back(r);
        n_total++;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // mostly short times so that blink cycles actually roll over
    function automatic logic [7:0] pick_ticks();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return 8'($urandom_range(1, 6));
        if (r < 85) return 8'($urandom_range(7, 20));
        if (r < 90) return 8'hff;
        return 8'($urandom);
    endfunction

    function automatic void fill_requests();
        int unsigned sel;
        int          idx;
        logic [7:0]  on_t;
        logic [7:0]  off_t;
        // directed: reset state, extremes, fallbacks, unchanged blink, flash run-out
        queue_req(mlbf_pkg::CMD_TICK, 0, 1'b0, 8'h00, 8'h00, 8'h00);
        queue_req(mlbf_pkg::CMD_TICK, 3, 1'b1, 8'hff, 8'hff, 8'hff);
        queue_req(mlbf_pkg::CMD_SET_CONST, 0, 1'b1, 8'h00, 8'h00, 8'h00);
        queue_req(mlbf_pkg::CMD_SET_CONST, 3, 1'b1, 8'hff, 8'hff, 8'hff);
        queue_req(mlbf_pkg::CMD_SET_CONST, 0, 1'b0, 8'h55, 8'haa, 8'h0f);
        queue_req(mlbf_pkg::CMD_SET_BLINK, 1, 1'b0, 8'h00, 8'h05, 8'h00);
        queue_req(mlbf_pkg::CMD_SET_BLINK, 1, 1'b0, 8'h05, 8'h00, 8'h00);
        queue_req(mlbf_pkg::CMD_SET_BLINK, 1, 1'b1, 8'h00, 8'h00, 8'h00);
        queue_req(mlbf_pkg::CMD_SET_BLINK, 1, 1'b0, 8'h02, 8'h03, 8'h00);
        repeat (3) queue_req(mlbf_pkg::CMD_TICK, 0, 1'b0, 8'h00, 8'h00, 8'h00);
        queue_req(mlbf_pkg::CMD_SET_BLINK, 1, 1'b0, 8'h02, 8'h03, 8'h00);
        repeat (3) queue_req(mlbf_pkg::CMD_TICK, 0, 1'b0, 8'h00, 8'h00, 8'h00);
        queue_req(mlbf_pkg::CMD_SET_BLINK, 2, 1'b1, 8'hff, 8'hff, 8'h00);
        queue_req(mlbf_pkg::CMD_START_FLASH, 3, 1'b0, 8'h00, 8'h00, 8'h00);
        queue_req(mlbf_pkg::CMD_START_FLASH, 3, 1'b0, 8'h00, 8'h00, 8'h02);
        queue_req(mlbf_pkg::CMD_START_FLASH, 0, 1'b1, 8'hff, 8'hff, 8'hff);
        repeat (5) queue_req(mlbf_pkg::CMD_TICK, 0, 1'b0, 8'h00, 8'h00, 8'h00);
        for (int i = 0; i < NLEDS; i++) begin
            last_on[i]  = 8'h01;
            last_off[i] = 8'h01;
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            sel = $urandom_range(0, 99);
            idx = $urandom_range(0, NLEDS - 1);
            if (sel < 62) begin
                // payload of a tick is junk and must be ignored
                queue_req(mlbf_pkg::CMD_TICK, idx, 1'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
            end else if (sel < 72) begin
                queue_req(mlbf_pkg::CMD_SET_CONST, idx, 1'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
            end else if (sel < 88) begin
                sel = $urandom_range(0, 99);
                if (sel < 25) begin
                    on_t  = last_on[idx];
                    off_t = last_off[idx];
                end else if (sel < 30) begin
                    on_t  = 8'h00;
                    off_t = pick_ticks();
                end else if (sel < 35) begin
                    on_t  = pick_ticks();
                    off_t = 8'h00;
                end else begin
                    on_t  = pick_ticks();
                    off_t = pick_ticks();
                end
                last_on[idx]  = on_t;
                last_off[idx] = off_t;
                queue_req(mlbf_pkg::CMD_SET_BLINK, idx, 1'($urandom), on_t, off_t,
                          8'($urandom));
            end else begin
                sel = $urandom_range(0, 99);
                queue_req(mlbf_pkg::CMD_START_FLASH, idx, 1'($urandom), 8'($urandom),
                          8'($urandom),
                          (sel < 8)  ? 8'h00 :
                          (sel < 18) ? 8'($urandom) : 8'($urandom_range(1, 5)));
            end
        end
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_led_model();
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                lamp_exp_q.push_back(apply_led_request(on_bus));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    on_bus = pending_reqs.pop_front();
                    s_tdata  <= mlbf_pkg::S_DATA_W'(on_bus.req);
                    s_tuser  <= on_bus.cmd;
                    s_tvalid <= 1'b1;
                    if (tx_calm != 0) begin
                        tx_calm--;
                    end else if ($urandom_range(0, 49) == 0) begin
                        tx_calm = $urandom_range(30, 80);
                    end else begin
                        tx_gap = pick_gap();
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        lamp_res_t want;
        lamp_res_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (lamp_exp_q.size() == 0) begin
                    $display("%0t: result with none pending, got %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = lamp_exp_q.pop_front();
                    if (got.levels !== want.levels) begin
                        $display("%0t: led_levels expected %h got %h",
                                 $time, want.levels, got.levels);
                        mismatches++;
                    end
                    if (got.active !== want.active) begin
                        $display("%0t: active_mask expected %h got %h",
                                 $time, want.active, got.active);
                        mismatches++;
                    end
                end
            end
            if (draining || rx_calm != 0) begin
                if (rx_calm != 0) rx_calm--;
                m_tready <= 1'b1;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) == 0) rx_calm = $urandom_range(40, 150);
                else rx_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        fill_requests();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (n_accepted < n_total || lamp_exp_q.size() != 0) @(posedge aclk);
        draining = 1'b1;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mlbf_pkg.sv
rtl/mlbf_led.sv
rtl/multi_led_blink_flash_controller_unit.sv
rtl/mlbf_checker.sv
verif/tb_multi_led_blink_flash_controller_unit.sv
